// ===== rtl/slb_pkg.sv =====
package slb_pkg;

   // fixed field widths
   localparam int THRESH_W = 12;
   localparam int WINDOW_W = 10;
   localparam int STEP_W   = 16;
   localparam int TIME_W   = 32;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic [THRESH_W-1:0] LOUD_THRESHOLD_RST = 12'd2500;
   localparam logic [WINDOW_W-1:0] WINDOW_MS_RST      = 10'd50;
   localparam logic [STEP_W-1:0]   STEP_MS_RST        = 16'd100;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOUD_THRESHOLD = 2'd0,
      CSR_WINDOW_MS      = 2'd1,
      CSR_STEP_MS        = 2'd2
   } csr_index_type;

   // one closed window as seen by the led bar
   typedef struct packed {
      logic              close;
      logic              loud;
      logic [TIME_W-1:0] now;
   } win_close_type;

endpackage

// ===== rtl/slb_bar.sv =====
module slb_bar
   import slb_pkg::*;
#(
   parameter int NUM_LEDS = 6,
   localparam int CNT_W = $clog2(NUM_LEDS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  win_close_type       win,
   input  logic [STEP_W-1:0]   step_ms,
   output logic [CNT_W-1:0]    lit_count,
   output logic                trigger
);

   logic              prior_loud_ff, prior_loud_in;
   logic [TIME_W-1:0] step_start_ff, step_start_in;
   logic [CNT_W-1:0]  lit_ff, lit_in;
   logic              fired_ff, fired_in;

   logic              changed;
   logic [TIME_W-1:0] elapsed;
   logic              due;
   logic              stepped;
   logic              trig;

   always_comb begin
      changed = win.loud != prior_loud_ff;
      // a loudness change restarts the step timer at the window start
      elapsed = changed ? '0 : win.now - step_start_ff;
      due     = elapsed >= TIME_W'(step_ms);
      lit_in   = lit_ff;
      fired_in = fired_ff;
      stepped  = 1'b0;
      trig     = 1'b0;
      if (win.loud) begin
         if (lit_ff < CNT_W'(NUM_LEDS)) begin
            fired_in = 1'b0;
            if (due) begin
               lit_in  = lit_ff + 1'b1;
               stepped = 1'b1;
            end
         end else if (!fired_ff && due) begin
            trig     = 1'b1;
            lit_in   = '0;
            fired_in = 1'b1;
            stepped  = 1'b1;
         end
      end else begin
         fired_in = 1'b0;
         if (lit_ff != '0 && due) begin
            lit_in  = lit_ff - 1'b1;
            stepped = 1'b1;
         end
      end
      step_start_in = (changed || stepped) ? win.now : step_start_ff;
      prior_loud_in = win.loud;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_loud_ff <= 1'b0;
         step_start_ff <= '0;
         lit_ff        <= '0;
         fired_ff      <= 1'b0;
      end else if (win.close) begin
         prior_loud_ff <= prior_loud_in;
         step_start_ff <= step_start_in;
         lit_ff        <= lit_in;
         fired_ff      <= fired_in;
      end
   end

   assign lit_count = lit_in;
   assign trigger   = trig;

endmodule

// ===== rtl/sound_level_led_bar.sv =====
// channel | dir | tdata (low bit up)                            | tuser
// --------+-----+-----------------------------------------------+-----------
// req_    | in  | sample                                        | cmd
// rsp_    | out | amplitude, loud, lit_count, led_mask, trigger | -
// csr_    | in  | csr_we / csr_index / csr_wdata, write only    | -
//
// one item per cycle unless a window-closing tick waits for result room;
// items pass the input register, and closing ticks then the result register
// the window check, peak-to-peak subtract and led bar step run in one pass
// from the input register, so the next item sees the updated state
// reset is synchronous and active high; config registers return to defaults
// a stalled result only holds a window-closing tick in the input register,
// which then holds off the input; samples and other ticks keep flowing

module sound_level_led_bar
   import slb_pkg::*;
#(
   parameter int NUM_LEDS    = 6,
   parameter int SAMPLE_BITS = 12,
   localparam int CNT_W       = $clog2(NUM_LEDS + 1),
   localparam int REQ_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_FIELD_W = SAMPLE_BITS + 1 + CNT_W + NUM_LEDS + 1,
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample
   input  logic                  req_tuser,   // cmd

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // amplitude, loud, lit_count, led_mask, trigger

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

   // config registers
   logic [THRESH_W-1:0] loud_threshold_ff, loud_threshold_in;
   logic [WINDOW_W-1:0] window_ms_ff, window_ms_in;
   logic [STEP_W-1:0]   step_ms_ff, step_ms_in;

   // input register
   logic                   in_valid_ff, in_valid_in;
   cmd_type                in_cmd_ff;
   logic [SAMPLE_BITS-1:0] in_sample_ff;

   // window state
   logic [TIME_W-1:0]      time_count_ff, time_count_in;
   logic [TIME_W-1:0]      window_start_ff, window_start_in;
   logic [SAMPLE_BITS-1:0] peak_high_ff, peak_high_in;
   logic [SAMPLE_BITS-1:0] peak_low_ff, peak_low_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_amp_ff;
   logic                   rsp_loud_ff;
   logic [CNT_W-1:0]       rsp_lit_ff;
   logic [NUM_LEDS-1:0]    rsp_mask_ff;
   logic                   rsp_trig_ff;

   logic [TIME_W-1:0]      time_next;
   logic                   win_close;
   logic                   produce;
   logic                   out_space;
   logic                   advance;
   logic [SAMPLE_BITS-1:0] amp;
   logic                   loud;
   win_close_type          win;
   logic [CNT_W-1:0]       lit_next;
   logic                   trig_next;
   logic [NUM_LEDS-1:0]    mask_next;

   // config writes
   always_comb begin
      loud_threshold_in = loud_threshold_ff;
      window_ms_in      = window_ms_ff;
      step_ms_in        = step_ms_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LOUD_THRESHOLD: loud_threshold_in = csr_wdata[THRESH_W-1:0];
            CSR_WINDOW_MS:      window_ms_in      = csr_wdata[WINDOW_W-1:0];
            CSR_STEP_MS:        step_ms_in        = csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // window close detection and amplitude
   always_comb begin
      time_next = time_count_ff + 1'b1;
      win_close = (time_next - window_start_ff) >= TIME_W'(window_ms_ff);
      produce   = in_valid_ff && (in_cmd_ff == CMD_TICK) && win_close;
      // no usable sample leaves high below low
      amp  = (peak_high_ff >= peak_low_ff) ? (peak_high_ff - peak_low_ff) : '0;
      loud = CMP_W'(amp) > CMP_W'(loud_threshold_ff);
      win.close = produce && out_space;
      win.loud  = loud;
      win.now   = window_start_ff;
   end

   // handshake: the input register drains unless a window-closing tick waits for result room
   assign out_space  = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!produce || out_space);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end
   end

   slb_bar #(
      .NUM_LEDS (NUM_LEDS)
   ) u_bar (
      .clock     (clock),
      .reset     (reset),
      .win       (win),
      .step_ms   (step_ms_ff),
      .lit_count (lit_next),
      .trigger   (trig_next)
   );

   // lowest lit_count bits set
   always_comb begin
      for (int i = 0; i < NUM_LEDS; i++) begin
         mask_next[i] = CNT_W'(i) < lit_next;
      end
   end

   // window state update
   always_comb begin
      time_count_in   = time_count_ff;
      window_start_in = window_start_ff;
      peak_high_in    = peak_high_ff;
      peak_low_in     = peak_low_ff;
      if (advance) begin
         case (in_cmd_ff)
            CMD_SAMPLE: begin
               // full-scale readings are clipped and ignored
               if (in_sample_ff != FULL_SCALE) begin
                  if (in_sample_ff > peak_high_ff) begin
                     peak_high_in = in_sample_ff;
                  end
                  if (in_sample_ff < peak_low_ff) begin
                     peak_low_in = in_sample_ff;
                  end
               end
            end
            CMD_TICK: begin
               time_count_in = time_next;
               if (win_close) begin
                  window_start_in = time_next;
                  peak_high_in    = '0;
                  peak_low_in     = FULL_SCALE;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && produce) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loud_threshold_ff <= LOUD_THRESHOLD_RST;
         window_ms_ff      <= WINDOW_MS_RST;
         step_ms_ff        <= STEP_MS_RST;
         in_valid_ff       <= 1'b0;
         time_count_ff     <= '0;
         window_start_ff   <= '0;
         peak_high_ff      <= '0;
         peak_low_ff       <= FULL_SCALE;
         rsp_valid_ff      <= 1'b0;
      end else begin
         loud_threshold_ff <= loud_threshold_in;
         window_ms_ff      <= window_ms_in;
         step_ms_ff        <= step_ms_in;
         in_valid_ff       <= in_valid_in;
         time_count_ff     <= time_count_in;
         window_start_ff   <= window_start_in;
         peak_high_ff      <= peak_high_in;
         peak_low_ff       <= peak_low_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff    <= cmd_type'(req_tuser);
         in_sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
      if (advance && produce) begin
         rsp_amp_ff  <= amp;
         rsp_loud_ff <= loud;
         rsp_lit_ff  <= lit_next;
         rsp_mask_ff <= mask_next;
         rsp_trig_ff <= trig_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_trig_ff, rsp_mask_ff, rsp_lit_ff,
                                    rsp_loud_ff, rsp_amp_ff});

`ifndef SYNTHESIS
   // a held input item stays put until it can drain
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_sample_ff)
                                   && $stable(in_cmd_ff))
      else $error("input register lost or changed a stalled item");

   // closing a window restarts both peaks
   a_peak_restart: assert property (@(posedge clock) disable iff (reset)
      advance && produce |=> peak_high_ff == '0 && peak_low_ff == FULL_SCALE)
      else $error("peaks not restarted after window close");

   // the trigger only fires on a loud window and empties the bar
   a_trig_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_trig_ff |-> rsp_loud_ff && rsp_lit_ff == '0)
      else $error("trigger without loud window or with bar still lit");

   // lit count never goes past the bar length
   a_lit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_lit_ff <= CNT_W'(NUM_LEDS))
      else $error("lit count beyond bar length");
`endif

endmodule

// ===== dv/sound_level_led_bar_tb.sv =====
module sound_level_led_bar_tb
   import slb_pkg::*;
;

   localparam int LEDS         = 6;
   localparam int SBITS        = 12;
   localparam int LIMIT_CYCLES = 500000;
   localparam int HOLD_CYCLES  = 250;
   localparam logic [11:0] FULL_SCALE = 12'hFFF;

   // one closed window, laid out as rsp_tdata from the low bit up
   typedef struct packed {
      logic       trigger;
      logic [5:0] led_mask;
      logic [2:0] lit_count;
      logic       loud;
      logic [11:0] amplitude;
   } window_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;   // sample
   logic                 req_tuser = 1'b0; // cmd

   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;        // amplitude, loud, lit_count, led_mask, trigger

   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   sound_level_led_bar #(
      .NUM_LEDS    (LEDS),
      .SAMPLE_BITS (SBITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // level meter prediction: own copy of registers and state
   // ---------------------------------------------------------------------
   logic [THRESH_W-1:0] cfg_threshold;
   logic [WINDOW_W-1:0] cfg_window;
   logic [STEP_W-1:0]   cfg_step;

   logic [31:0] tick_now;
   logic [31:0] win_begin;
   logic [11:0] peak_hi;
   logic [11:0] peak_lo;
   logic        was_loud;
   logic [31:0] step_begin;
   logic [2:0]  leds_lit;
   logic        shot_done;

   window_result_type expected_windows[$];

   int  mismatches = 0;
   int  cycles     = 0;
   logic no_gaps   = 1'b0;   // set for stretches without any idling
   int  hold_req   = 0;      // bumped to ask the receiver for a long hold-off

   task automatic reset_meter();
      cfg_threshold = LOUD_THRESHOLD_RST;
      cfg_window    = WINDOW_MS_RST;
      cfg_step      = STEP_MS_RST;
      tick_now      = '0;
      win_begin     = '0;
      peak_hi       = '0;
      peak_lo       = FULL_SCALE;
      was_loud      = 1'b0;
      step_begin    = '0;
      leds_lit      = '0;
      shot_done     = 1'b0;
   endtask

   // led bar step for one closed window; returns the trigger pulse
   function automatic logic led_bar_advance(input logic loud_now, input logic [31:0] at);
      logic trig;
      logic due;
      trig = 1'b0;
      if (loud_now != was_loud) begin
         step_begin = at;
         was_loud   = loud_now;
      end
      due = (at - step_begin) >= {16'd0, cfg_step};
      if (loud_now) begin
         if (leds_lit < LEDS) begin
            shot_done = 1'b0;
            if (due) begin
               leds_lit   = leds_lit + 3'd1;
               step_begin = at;
            end
         end else if (!shot_done && due) begin
            trig       = 1'b1;
            leds_lit   = '0;
            shot_done  = 1'b1;
            step_begin = at;
         end
      end else begin
         shot_done = 1'b0;
         if (leds_lit > 0 && due) begin
            leds_lit   = leds_lit - 3'd1;
            step_begin = at;
         end
      end
      return trig;
   endfunction

   task automatic meter_step(input cmd_type c, input logic [11:0] s);
      window_result_type r;
      logic [11:0] amp;
      logic        loud_now;
      if (c == CMD_SAMPLE) begin
         // full-scale readings are clipping, not sound
         if (s != FULL_SCALE) begin
            if (s > peak_hi) peak_hi = s;
            if (s < peak_lo) peak_lo = s;
         end
         return;
      end
      tick_now = tick_now + 32'd1;
      if ((tick_now - win_begin) < {22'd0, cfg_window}) return;
      // empty window leaves peak_hi below peak_lo
      amp         = (peak_hi >= peak_lo) ? (peak_hi - peak_lo) : 12'd0;
      loud_now    = amp > cfg_threshold;
      r.trigger   = led_bar_advance(loud_now, win_begin);
      r.amplitude = amp;
      r.loud      = loud_now;
      r.lit_count = leds_lit;
      r.led_mask  = 6'((7'd1 << leds_lit) - 7'd1);
      win_begin   = tick_now;
      peak_hi     = '0;
      peak_lo     = FULL_SCALE;
      expected_windows.push_back(r);
   endtask

   // ---------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic send_item(input cmd_type c, input logic [11:0] s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {4'd0, s};
      do @(posedge clock); while (!req_tready);
      meter_step(c, s);
   endtask

   // sender pauses until every expected window has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_windows.size() != 0) @(posedge clock);
      // a plain sample or tick may still sit in the input register
      repeat (8) @(posedge clock);
   endtask

   task automatic write_regs(input logic [11:0] thr, input logic [9:0] win,
                             input logic [15:0] step);
      csr_we    <= 1'b1;
      csr_index <= CSR_LOUD_THRESHOLD;
      csr_wdata <= {4'd0, thr};
      @(posedge clock);
      csr_index <= CSR_WINDOW_MS;
      csr_wdata <= {6'd0, win};
      @(posedge clock);
      csr_index <= CSR_STEP_MS;
      csr_wdata <= step;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_threshold = thr;
      cfg_window    = win;
      cfg_step      = step;
   endtask

   // sample for a loud or a quiet window, with some clipping and noise
   function automatic logic [11:0] pick_sample(input logic loud_win);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return FULL_SCALE;
      if (r < 12) return 12'($urandom_range(0, 4095));
      if (loud_win)
         return $urandom_range(0, 1) ? 12'($urandom_range(0, 300))
                                     : 12'($urandom_range(3800, 4094));
      return 12'($urandom_range(1900, 2100));
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      // threshold zero, one-tick window, zero step: every window may step
      write_regs(12'd0, 10'd1, 16'd0);
      send_item(CMD_SAMPLE, 12'd0);
      send_item(CMD_SAMPLE, FULL_SCALE);      // clipped, ignored
      send_item(CMD_SAMPLE, 12'd4094);
      send_item(CMD_TICK, 12'd0);              // widest amplitude
      send_item(CMD_SAMPLE, FULL_SCALE);
      send_item(CMD_TICK, 12'd0);              // only clipping: empty window
      send_item(CMD_TICK, 12'd0);              // no sample at all
      send_item(CMD_SAMPLE, 12'd2048);
      send_item(CMD_TICK, 12'd0);              // one sample, zero amplitude
      send_item(CMD_SAMPLE, 12'd1);
      send_item(CMD_SAMPLE, 12'd2);
      send_item(CMD_TICK, 12'd0);              // amplitude one above zero threshold
      send_item(CMD_SAMPLE, 12'hAAA);
      send_item(CMD_SAMPLE, 12'h555);
      send_item(CMD_TICK, 12'hFFF);
      wait_drained();
      // top threshold and zero window length: each tick closes, never loud
      write_regs(12'd4095, 10'd0, 16'd1);
      send_item(CMD_SAMPLE, 12'd0);
      send_item(CMD_SAMPLE, 12'd4094);
      send_item(CMD_TICK, 12'd0);
      send_item(CMD_TICK, 12'd0);
      send_item(CMD_TICK, 12'd0);
      wait_drained();
   endtask

   task automatic test_random_windows();
      int   made;
      int   r;
      int   n_win;
      int   slots;
      int   n_samp;
      logic loud_run;
      logic [11:0] thr;
      logic [9:0]  win;
      logic [15:0] step;
      made     = 0;
      loud_run = 1'b0;
      while (made < 500) begin
         r = $urandom_range(0, 99);
         if (r < 10)      thr = 12'd0;
         else if (r < 20) thr = 12'd4095;
         else             thr = 12'($urandom_range(500, 3800));
         r = $urandom_range(0, 99);
         if (r < 70)      win = 10'($urandom_range(1, 4));
         else if (r < 92) win = 10'($urandom_range(5, 20));
         else             win = 10'd0;
         r = $urandom_range(0, 99);
         if (r < 15)      step = 16'd0;
         else if (r < 75) step = 16'($urandom_range(1, 8));
         else if (r < 95) step = 16'($urandom_range(9, 60));
         else             step = 16'd65535;
         write_regs(thr, win, step);
         no_gaps <= ($urandom_range(0, 4) == 0);
         n_win = $urandom_range(6, 30);
         for (int w = 0; w < n_win; w++) begin
            // loudness runs long enough to fill the bar and fire
            if ($urandom_range(0, 9) == 0) loud_run = !loud_run;
            slots = (cfg_window == 0) ? 1 : cfg_window;
            for (int t = 0; t < slots; t++) begin
               n_samp = $urandom_range(0, 3);
               repeat (n_samp) begin
                  send_item(CMD_SAMPLE, pick_sample(loud_run));
                  made++;
               end
               // stray tick breaks the window alignment now and then
               if ($urandom_range(0, 19) == 0) begin
                  send_item(CMD_TICK, 12'($urandom_range(0, 4095)));
                  made++;
               end
               send_item(CMD_TICK, 12'($urandom_range(0, 4095)));
               made++;
            end
         end
         wait_drained();
         no_gaps <= 1'b0;
      end
   endtask

   task automatic test_long_window();
      write_regs(12'($urandom_range(500, 3500)), 10'd1023, 16'd65535);
      for (int t = 0; t < 1030; t++) begin
         if ($urandom_range(0, 39) == 0)
            send_item(CMD_SAMPLE, pick_sample(1'($urandom_range(0, 1))));
         send_item(CMD_TICK, 12'd0);
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      // one-tick windows so every tick makes a result
      write_regs(12'd1000, 10'd1, 16'd1);
      no_gaps  <= 1'b1;
      hold_req <= hold_req + 1;
      repeat (40) begin
         send_item(CMD_SAMPLE, pick_sample(1'b1));
         send_item(CMD_TICK, 12'd0);
      end
      wait_drained();
      no_gaps <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // receiver: random stalls, long hold-off on request, result check
   // ---------------------------------------------------------------------
   int hold_done = 0;
   int hold_left = 0;
   int stall_left = 0;

   task automatic note_miss(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10)
         $display("window result %s: expected %0d, got %0d", what, want, got);
   endtask

   always @(posedge clock) begin
      window_result_type got;
      window_result_type want;
      int r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = window_result_type'(rsp_tdata[22:0]);
         if (expected_windows.size() == 0) begin
            note_miss("with nothing expected, amplitude", -1, got.amplitude);
         end else begin
            want = expected_windows.pop_front();
            if (got.amplitude != want.amplitude)
               note_miss("amplitude", want.amplitude, got.amplitude);
            if (got.loud != want.loud)
               note_miss("loud", want.loud, got.loud);
            if (got.lit_count != want.lit_count)
               note_miss("lit_count", want.lit_count, got.lit_count);
            if (got.led_mask != want.led_mask)
               note_miss("led_mask", want.led_mask, got.led_mask);
            if (got.trigger != want.trigger)
               note_miss("trigger", want.trigger, got.trigger);
         end
      end
      // ready for the next edge
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_req != hold_done) begin
         hold_done = hold_req;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 99) < 12) begin
         r = $urandom_range(0, 99);
         if (r < 80)      stall_left = $urandom_range(0, 3);
         else if (r < 96) stall_left = $urandom_range(4, 12);
         else             stall_left = $urandom_range(20, 60);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("sound_level_led_bar: mismatch");
         $finish;
      end
   end

   initial begin
      reset_meter();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_windows();
      test_long_window();
      test_backpressure();
      req_tvalid <= 1'b0;
      while (expected_windows.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_windows.size() == 0) begin
         $display("sound_level_led_bar: match");
      end else begin
         $display("sound_level_led_bar: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/slb_pkg.sv
rtl/slb_bar.sv
rtl/sound_level_led_bar.sv
dv/sound_level_led_bar_tb.sv
